// ----- design/tle_pkg.sv -----
// Shared constants and types for the terminal line editor.
package tle_pkg;

    // Command opcodes
    localparam logic [1:0] OP_BYTE = 2'd0;
    localparam logic [1:0] OP_END  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_ECHO = 2'd0;
    localparam logic [1:0] KIND_LINE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;
    localparam logic [1:0] KIND_READ = 2'd3;

    // Character codes
    localparam logic [7:0] CH_BELL  = 8'h07;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // Result descriptor handed from the edit stage to the emit stage
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;      // echo byte, zero otherwise
        logic [7:0] len;       // line length for KIND_LINE
        logic       erase;     // emit BS, SP, BS
        logic       use_mem;   // take byte from the line store read port
    } desc_t;

    // Line store access from the edit stage
    typedef struct packed {
        logic       we;
        logic [7:0] waddr;
        logic [7:0] wdata;
        logic       re;
        logic [7:0] raddr;
    } store_req_t;

endpackage

// ----- design/tle_cmd_if.sv -----
// Command channel: opcode, terminal byte and read index.
interface tle_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [7:0] read_index;

    modport source (output valid, output opcode, output data_byte, output read_index,
                    input ready);
    modport sink   (input valid, input opcode, input data_byte, input read_index,
                    output ready);
endinterface

// ----- design/tle_rsp_if.sv -----
// Result channel: kind, byte, line length and end-of-run flag.
interface tle_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic [7:0] line_length;
    logic       last_of_run;

    modport source (output valid, output out_kind, output out_byte, output line_length,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_kind, input out_byte, input line_length,
                    input last_of_run, output ready);
endinterface

// ----- design/tle_store.sv -----
// Line store: one write port, one read port with registered data.
module tle_store #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                clk,
    input  tle_pkg::store_req_t req,
    output logic [7:0]          rdata
);

    localparam int ADDR_W = $clog2(STORE_DEPTH);

    logic [7:0] mem [STORE_DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr[ADDR_W-1:0]] <= req.wdata;
        end
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr[ADDR_W-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/tle_edit.sv -----
// Edit stage: command register, cursor, line size and the per-byte decision.
module tle_edit #(
    parameter int STORE_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tle_cmd_if.sink              cmd,
    input  logic                 cfg_we,
    input  logic [8:0]           cfg_wdata,
    input  logic                 emit_free,
    output logic                 desc_load,
    output tle_pkg::desc_t       desc,
    output tle_pkg::store_req_t  store_req
);

    localparam logic [8:0] DEPTH_W = 9'(STORE_DEPTH);

    logic       in_valid_reg;
    logic [1:0] op_reg;
    logic [7:0] byte_reg;
    logic [7:0] idx_reg;
    logic [7:0] cursor_reg, cursor_next;
    logic [8:0] limit_reg, limit_next;
    logic [8:0] size_clip;

    logic has_res;
    logic advance;
    logic accept;

    assign accept  = cmd.valid && cmd.ready;
    assign advance = in_valid_reg && (!has_res || emit_free);
    assign cmd.ready = !in_valid_reg || advance;
    assign desc_load = advance && has_res;

    // acceptance limit, worked out once per write
    assign size_clip  = (cfg_wdata > DEPTH_W) ? DEPTH_W : cfg_wdata;
    assign limit_next = (size_clip < 9'd2) ? 9'd0 : size_clip - 9'd2;

    always_comb
    begin
        desc        = '0;
        has_res     = 1'b0;
        cursor_next = cursor_reg;
        store_req   = '0;
        store_req.raddr = idx_reg;
        store_req.waddr = cursor_reg;
        unique case (op_reg)
            tle_pkg::OP_BYTE:
            begin
                has_res = 1'b1;
                if (byte_reg == tle_pkg::CH_CR || byte_reg == tle_pkg::CH_LF)
                begin
                    desc.kind       = tle_pkg::KIND_LINE;
                    desc.len        = cursor_reg;
                    store_req.we    = 1'b1;
                    store_req.wdata = 8'h00;
                    cursor_next     = 8'd0;
                end
                else if (byte_reg == tle_pkg::CH_BS)
                begin
                    desc.kind = tle_pkg::KIND_ECHO;
                    if (cursor_reg != 8'd0)
                    begin
                        desc.erase  = 1'b1;
                        desc.data   = tle_pkg::CH_BS;
                        cursor_next = cursor_reg - 8'd1;
                    end
                    else
                    begin
                        desc.data = tle_pkg::CH_BELL;
                    end
                end
                else if ({1'b0, cursor_reg} < limit_reg)
                begin
                    desc.kind       = tle_pkg::KIND_ECHO;
                    desc.data       = byte_reg;
                    store_req.we    = 1'b1;
                    store_req.wdata = byte_reg;
                    cursor_next     = cursor_reg + 8'd1;
                    // non-printable bytes are stored silently
                    has_res = (byte_reg >= tle_pkg::CH_SPACE) && (byte_reg < tle_pkg::CH_DEL);
                end
                else
                begin
                    desc.kind = tle_pkg::KIND_ECHO;
                    desc.data = tle_pkg::CH_BELL;
                end
            end
            tle_pkg::OP_END:
            begin
                has_res     = 1'b1;
                desc.kind   = tle_pkg::KIND_ERR;
                cursor_next = 8'd0;
            end
            tle_pkg::OP_READ:
            begin
                has_res      = 1'b1;
                desc.kind    = tle_pkg::KIND_READ;
                desc.use_mem = ({1'b0, idx_reg} < DEPTH_W);
            end
            default:
            begin
                has_res = 1'b0;
            end
        endcase
        // same terms as advance / desc_load, built from the local has_res
        if (!(in_valid_reg && (!has_res || emit_free)))
        begin
            store_req.we = 1'b0;
        end
        store_req.re = in_valid_reg && emit_free && desc.use_mem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cursor_reg   <= 8'd0;
            limit_reg    <= DEPTH_W - 9'd2;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                cursor_reg <= cursor_next;
            end
            if (cfg_we)
            begin
                limit_reg <= limit_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= cmd.opcode;
            byte_reg <= cmd.data_byte;
            idx_reg  <= cmd.read_index;
        end
    end

endmodule

// ----- design/tle_emit.sv -----
// Emit stage: result register and sequencer for up to three results per transaction.
module tle_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            desc_load,
    input  tle_pkg::desc_t  desc,
    input  logic [7:0]      mem_rdata,
    output logic            free,
    tle_rsp_if.source       rsp
);

    tle_pkg::desc_t desc_reg;
    logic           valid_reg;
    logic [1:0]     step_reg;
    logic           last;
    logic           take;

    assign last = desc_reg.erase ? (step_reg == 2'd2) : 1'b1;
    assign take = valid_reg && rsp.ready;
    assign free = !valid_reg || (rsp.ready && last);

    assign rsp.valid       = valid_reg;
    assign rsp.out_kind    = desc_reg.kind;
    assign rsp.line_length = desc_reg.len;
    assign rsp.last_of_run = last;

    always_comb
    begin
        if (desc_reg.use_mem)
        begin
            rsp.out_byte = mem_rdata;
        end
        else if (desc_reg.erase && step_reg == 2'd1)
        begin
            rsp.out_byte = tle_pkg::CH_SPACE;
        end
        else
        begin
            rsp.out_byte = desc_reg.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            step_reg  <= 2'd0;
        end
        else
        begin
            if (take && !last)
            begin
                step_reg <= step_reg + 2'd1;
            end
            else if (free)
            begin
                step_reg  <= 2'd0;
                valid_reg <= desc_load;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (desc_load)
        begin
            desc_reg <= desc;
        end
    end

endmodule

// ----- design/terminal_line_editor.sv -----
// Terminal line editor: builds a text line from terminal bytes, echoes, and reads it back.
//
// Each command transaction is taken into an input register, decided against
// the cursor and the line size register, and handed to an output register
// that presents its results one per cycle while the receiver is ready. A
// command can be taken every cycle while results are accepted: commands with
// no result or one result (plain bytes, line end, bell, stream end, store
// read) sustain one per cycle, while a backspace that erases holds the output
// for its three results (BS, space, BS). A command passes the input register
// and the result register before its first result is presented. The line
// store holds LINE_DEPTH bytes (at most 256) with a registered read port.
// Entries need no clearing after reset if each is read only after it is written,
// and line_size is written through cfg_we / cfg_wdata only while the block is
// idle and takes effect at once; the user must keep both, the block enforces neither.
module terminal_line_editor #(
    parameter int LINE_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [8:0] cfg_wdata,
    tle_cmd_if.sink    cmd,
    tle_rsp_if.source  rsp
);

    // Only 256 positions are reachable through 8-bit cursor and read index.
    localparam int STORE_DEPTH = (LINE_DEPTH < 256) ? LINE_DEPTH : 256;

    tle_pkg::desc_t      desc;
    tle_pkg::store_req_t store_req;
    logic                desc_load;
    logic                emit_free;
    logic [7:0]          mem_rdata;

    // decision stage: cursor, limit and store writes
    tle_edit #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_edit (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .emit_free (emit_free),
        .desc_load (desc_load),
        .desc      (desc),
        .store_req (store_req)
    );

    // line store; read data lines up with the result register
    tle_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (mem_rdata)
    );

    // result sequencer
    tle_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .desc_load (desc_load),
        .desc      (desc),
        .mem_rdata (mem_rdata),
        .free      (emit_free),
        .rsp       (rsp)
    );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking bench for the terminal line editor: stimulus, line predictor and result checks.
`timescale 1ns / 100ps

module tb_top;

    localparam int LINE_DEPTH = 256;

    // Opcode 3 has no meaning; the editor must drop it without a result
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One command transaction and one result transaction
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
        logic [7:0] read_index;
    } cmd_txn_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [7:0] len;
        logic       last;
    } rsp_txn_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [8:0] cfg_wdata;

    tle_cmd_if cmd_ch();
    tle_rsp_if rsp_ch();

    terminal_line_editor #(
        .LINE_DEPTH(LINE_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .cmd      (cmd_ch),
        .rsp      (rsp_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted editor state: cursor, line store and the line size setting.
    // written_mask marks store entries that hold a defined byte; reads are
    // only ever aimed at those.
    // ------------------------------------------------------------------
    logic [7:0] cursor_q;
    logic [7:0] line_mem [LINE_DEPTH];
    bit         written_mask [LINE_DEPTH];
    logic [8:0] line_size_reg = 9'd256;

    cmd_txn_t   cmds_pending [$];   // commands waiting for the driver
    rsp_txn_t   results_due  [$];   // predicted results, oldest first

    // Traffic shaping, changed between phases
    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    bit  hold_request   = 1'b0;
    logic rsp_hold      = 1'b0;

    // Run statistics
    int fail_count     = 0;
    int accepted_count = 0;
    int checked_count  = 0;
    int lines_done     = 0;
    int longest_line   = 0;
    int erase_count    = 0;
    int read_count     = 0;

    // Work out the results of one accepted command and advance the state.
    function automatic void edit_line(input cmd_txn_t c);
        rsp_txn_t run [3];
        int       n;
        int       eff_size;
        int       limit;
        n = 0;
        // At most line_size - 2 characters fit; the store caps the size
        eff_size = (line_size_reg > LINE_DEPTH) ? LINE_DEPTH : int'(line_size_reg);
        limit    = (eff_size < 2) ? 0 : eff_size - 2;
        case (c.opcode)
            tle_pkg::OP_BYTE:
            begin
                if (c.data_byte == tle_pkg::CH_CR || c.data_byte == tle_pkg::CH_LF)
                begin
                    // line end: zero terminator, report the length
                    line_mem[cursor_q]     = 8'h00;
                    written_mask[cursor_q] = 1'b1;
                    run[n] = '{tle_pkg::KIND_LINE, 8'h00, cursor_q, 1'b0};
                    n++;
                    lines_done++;
                    if (int'(cursor_q) > longest_line)
                        longest_line = int'(cursor_q);
                    cursor_q = 8'd0;
                end
                else if (c.data_byte == tle_pkg::CH_BS)
                begin
                    if (cursor_q != 8'd0)
                    begin
                        // erase on screen: BS, space, BS
                        run[0] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 8'd0, 1'b0};
                        run[1] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_SPACE, 8'd0, 1'b0};
                        run[2] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_BS, 8'd0, 1'b0};
                        n = 3;
                        cursor_q = cursor_q - 8'd1;
                        erase_count++;
                    end
                    else
                    begin
                        run[n] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_BELL, 8'd0, 1'b0};
                        n++;
                    end
                end
                else if (int'(cursor_q) < limit)
                begin
                    line_mem[cursor_q]     = c.data_byte;
                    written_mask[cursor_q] = 1'b1;
                    cursor_q = cursor_q + 8'd1;
                    // only printable characters are echoed
                    if (c.data_byte >= tle_pkg::CH_SPACE && c.data_byte < tle_pkg::CH_DEL)
                    begin
                        run[n] = '{tle_pkg::KIND_ECHO, c.data_byte, 8'd0, 1'b0};
                        n++;
                    end
                end
                else
                begin
                    // line full
                    run[n] = '{tle_pkg::KIND_ECHO, tle_pkg::CH_BELL, 8'd0, 1'b0};
                    n++;
                end
            end
            tle_pkg::OP_END:
            begin
                cursor_q = 8'd0;
                run[n] = '{tle_pkg::KIND_ERR, 8'h00, 8'd0, 1'b0};
                n++;
            end
            tle_pkg::OP_READ:
            begin
                run[n] = '{tle_pkg::KIND_READ, line_mem[c.read_index], 8'd0, 1'b0};
                n++;
                read_count++;
            end
            default:
            begin
                // unused opcode: dropped silently
            end
        endcase
        for (int k = 0; k < n; k++)
        begin
            run[k].last = (k == n - 1);
            results_due.push_back(run[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Command driver. offering mirrors cmd_ch.valid; a transaction is taken
    // at an edge where valid and ready were both high. Each signal gets a
    // single nonblocking update per edge.
    // ------------------------------------------------------------------
    cmd_txn_t offer_item;
    bit       offering = 1'b0;

    always @(posedge clk)
    begin
        bit free;
        free = !offering || cmd_ch.ready;
        if (offering && cmd_ch.ready)
        begin
            edit_line(offer_item);
            accepted_count++;
        end
        if (free)
        begin
            if (rst_n && cmds_pending.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                offer_item = cmds_pending.pop_front();
                offering   = 1'b1;
                cmd_ch.valid      <= 1'b1;
                cmd_ch.opcode     <= offer_item.opcode;
                cmd_ch.data_byte  <= offer_item.data_byte;
                cmd_ch.read_index <= offer_item.read_index;
            end
            else
            begin
                offering = 1'b0;
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: every accepted result is checked against the oldest
    // prediction, then ready is chosen for the next cycle.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rsp_txn_t want;
        bit       bad;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (results_due.size() == 0)
            begin
                $error("unexpected result: kind %0d byte %02h len %0d last %0d",
                       rsp_ch.out_kind, rsp_ch.out_byte, rsp_ch.line_length,
                       rsp_ch.last_of_run);
                fail_count++;
            end
            else
            begin
                want = results_due.pop_front();
                bad  = 1'b0;
                if (rsp_ch.out_kind !== want.kind)
                begin
                    $error("out_kind: expected %0d, got %0d", want.kind, rsp_ch.out_kind);
                    bad = 1'b1;
                end
                if (rsp_ch.out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, rsp_ch.out_byte);
                    bad = 1'b1;
                end
                if (rsp_ch.line_length !== want.len)
                begin
                    $error("line_length: expected %0d, got %0d", want.len,
                           rsp_ch.line_length);
                    bad = 1'b1;
                end
                if (rsp_ch.last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0d, got %0d", want.last,
                           rsp_ch.last_of_run);
                    bad = 1'b1;
                end
                if (bad)
                    fail_count++;
                checked_count++;
            end
        end
        rsp_ch.ready <= rst_n && !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted here so the sender keeps pushing and
    // the editor backs up into its command port.
    initial
    begin
        wait (hold_request);
        rsp_hold <= 1'b1;
        repeat (150) @(posedge clk);
        rsp_hold <= 1'b0;
    end

    // Run limit
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // Keep the driver queue short so read targets come from a fresh view
    // of which store entries have been written.
    task automatic send_cmd(input logic [1:0] op, input logic [7:0] data,
                            input logic [7:0] idx);
        while (cmds_pending.size() >= 4)
            @(posedge clk);
        cmds_pending.push_back('{op, data, idx});
    endtask

    task automatic type_key(input logic [7:0] key);
        send_cmd(tle_pkg::OP_BYTE, key, 8'($urandom));
    endtask

    // Find a store entry that holds a defined byte
    function automatic bit pick_stored_index(output logic [7:0] idx);
        int start;
        start = $urandom_range(LINE_DEPTH - 1);
        idx   = 8'd0;
        for (int k = 0; k < LINE_DEPTH; k++)
        begin
            if (written_mask[(start + k) % LINE_DEPTH])
            begin
                idx = 8'((start + k) % LINE_DEPTH);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Wait until every command is taken and every result has come back,
    // then allow for silent commands still inside the pipeline.
    task automatic wait_drained();
        while (cmds_pending.size() != 0 || offering || results_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic start_phase(input logic [8:0] size, input int send_pct,
                               input int recv_pct);
        wait_drained();
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= size;
        @(posedge clk);
        cfg_we <= 1'b0;
        line_size_reg  = size;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // One typed line: mostly printable keys with erases, control bytes,
    // stray reads, dropped opcodes and the odd stream end, then CR or LF.
    task automatic random_line(input int keys);
        int         r;
        logic [7:0] b;
        logic [7:0] idx;
        for (int k = 0; k < keys; k++)
        begin
            r = $urandom_range(99);
            if (r < 70)
                type_key(8'($urandom_range(8'h7E, 8'h20)));
            else if (r < 82)
                type_key(tle_pkg::CH_BS);
            else if (r < 90)
            begin
                b = 8'($urandom);
                if (b == tle_pkg::CH_CR || b == tle_pkg::CH_LF)
                    b = tle_pkg::CH_DEL;
                type_key(b);
            end
            else if (r < 94 && pick_stored_index(idx))
                send_cmd(tle_pkg::OP_READ, 8'($urandom), idx);
            else if (r < 97)
                send_cmd(OP_UNUSED, 8'($urandom), 8'($urandom));
            else
                send_cmd(tle_pkg::OP_END, 8'($urandom), 8'($urandom));
        end
        type_key($urandom_range(1) ? tle_pkg::CH_CR : tle_pkg::CH_LF);
    endtask

    // Fully random commands; a read goes to a defined entry only
    task automatic random_noise(input int n);
        logic [1:0] op;
        logic [7:0] idx;
        for (int k = 0; k < n; k++)
        begin
            op  = 2'($urandom);
            idx = 8'($urandom);
            if (op == tle_pkg::OP_READ && !pick_stored_index(idx))
                op = tle_pkg::OP_END;
            send_cmd(op, 8'($urandom), idx);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = 9'd0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.opcode     = tle_pkg::OP_BYTE;
        cmd_ch.data_byte  = 8'h00;
        cmd_ch.read_index = 8'h00;
        rsp_ch.ready      = 1'b0;
        cursor_q          = 8'd0;
        for (int k = 0; k < LINE_DEPTH; k++)
        begin
            line_mem[k]     = 8'h00;
            written_mask[k] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset line size
        type_key(tle_pkg::CH_BS);                   // erase at line start: bell
        type_key(tle_pkg::CH_SPACE);                // lowest printable
        type_key(8'h7E);                            // highest printable
        type_key(tle_pkg::CH_DEL);                  // stored, silent
        type_key(8'h00);                            // stored, silent
        type_key(8'hFF);                            // stored, silent
        type_key(8'h1F);                            // stored, silent
        type_key(tle_pkg::CH_BS);                   // erase: BS, space, BS
        type_key(tle_pkg::CH_CR);                   // line of five
        send_cmd(tle_pkg::OP_READ, 8'hFF, 8'd0);
        send_cmd(tle_pkg::OP_READ, 8'h00, 8'd2);
        send_cmd(tle_pkg::OP_READ, 8'h5A, 8'd4);
        send_cmd(tle_pkg::OP_READ, 8'hA5, 8'd5);    // terminator
        type_key("Z");
        send_cmd(tle_pkg::OP_END, 8'h00, 8'hFF);    // stream end mid-line
        type_key(tle_pkg::CH_LF);                   // empty line
        send_cmd(tle_pkg::OP_READ, 8'h00, 8'd0);
        send_cmd(OP_UNUSED, 8'hFF, 8'hFF);          // ignored
        send_cmd(tle_pkg::OP_END, 8'hFF, 8'h00);    // stream end at line start

        // Full speed, then a long receiver hold-off with the sender pushing
        start_phase(9'd256, 0, 0);
        hold_request = 1'b1;
        random_line(20);
        random_line(20);

        // Smallest sizes: nothing fits, every key but a line end bells
        start_phase(9'd2, 47, 0);
        random_line(6);
        random_noise(4);
        start_phase(9'd0, 0, 47);
        random_line(5);
        start_phase(9'd1, 9, 9);
        random_line(3);

        // Room for one character
        start_phase(9'd3, 9, 9);
        random_line(4);
        random_line(4);

        // Oversized setting, clamped by the store
        start_phase(9'h1FF, 0, 0);
        random_line(15);

        // Small size with overflow, receiver stalling
        start_phase(9'd16, 0, 47);
        random_line(30);
        random_noise(6);

        // Back to the reset size, both sides idling
        start_phase(9'd256, 9, 9);
        random_line($urandom_range(14, 8));
        random_noise(6);

        wait_drained();
        repeat (20) @(posedge clk);

        $display("Ran %0d commands over 8 phases, line size 0 to 511; %0d results checked.",
                 accepted_count, checked_count);
        $display("Lines ended: %0d, longest %0d; erases %0d; store reads %0d.",
                 lines_done, longest_line, erase_count, read_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
